// ===== src/cht_pkg.sv =====
// Shared types, codes and constants of the chained hash table.
// No dependencies; every other file of the block except cht_ram refers to it by scoped names.
package cht_pkg;

   localparam int NUM_BUCKETS_DEFAULT    = 256;
   localparam int ENTRY_CAPACITY_DEFAULT = 1024;

   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 11;

   localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;
   localparam logic [KEY_W-1:0] HASH_MOD  = 32'hffff_ffff;

   // bucket reduction for non power-of-two bucket counts: 4-bit digits
   localparam int DIGIT_W     = 4;
   localparam int HASH_DIGITS = KEY_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(HASH_DIGITS + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NEW     = 3'd0,
      STAT_UPDATED = 3'd1,
      STAT_FOUND   = 3'd2,
      STAT_MISSING = 3'd3,
      STAT_FULL    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_WALK,
      ST_DECIDE,
      ST_LINK
   } state_type;

endpackage

// ===== src/cht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cht_hash.sv =====
// Bucket hash: (key * HASH_MULT) mod 0xffffffff, then mod NUM_BUCKETS.
// Depends on cht_pkg. Power-of-two bucket counts mask; others reduce one digit a cycle.
module cht_hash #(
   parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEFAULT,
   localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cht_pkg::KEY_W-1:0] key,
   output logic                      done,
   output logic [BKT_W-1:0]          bucket
);

   localparam int KW = cht_pkg::KEY_W;
   localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

   logic [2*KW-1:0] prod_ff, prod_in;
   logic [KW:0]     sum_ff, sum_in;
   logic            v1_ff, v2_ff;
   logic [KW:0]     sum_sub;
   logic [KW-1:0]   h_mod;

   assign prod_in = (2*KW)'(key) * (2*KW)'(cht_pkg::HASH_MULT);
   assign sum_in  = {1'b0, prod_ff[2*KW-1:KW]} + {1'b0, prod_ff[KW-1:0]};
   assign sum_sub = sum_ff - {1'b0, cht_pkg::HASH_MOD};
   assign h_mod   = (sum_ff >= {1'b0, cht_pkg::HASH_MOD}) ? sum_sub[KW-1:0] : sum_ff[KW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   generate
      if (IS_POW2) begin : g_mask
         logic [KW-1:0]    masked;
         logic [BKT_W-1:0] bucket_ff;
         logic             done_ff;

         assign masked = h_mod & KW'(NUM_BUCKETS - 1);

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= v2_ff;
            end
            if (v2_ff) begin
               bucket_ff <= masked[BKT_W-1:0];
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end else begin : g_digit
         localparam int XW = BKT_W + cht_pkg::DIGIT_W;

         logic [KW-1:0]                   sh_ff, sh_in;
         logic [BKT_W-1:0]                rem_ff, rem_in;
         logic [cht_pkg::DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
         logic                            done_ff, done_in;
         logic [XW-1:0]                   x, r;

         always_comb begin
            x = {rem_ff, sh_ff[KW-1 -: cht_pkg::DIGIT_W]};
            r = x;
            for (int q = 1; q < (1 << cht_pkg::DIGIT_W); q++) begin
               if (x >= XW'(q * NUM_BUCKETS)) begin
                  r = x - XW'(q * NUM_BUCKETS);
               end
            end
            sh_in   = sh_ff;
            rem_in  = rem_ff;
            cnt_in  = cnt_ff;
            done_in = 1'b0;
            if (v2_ff) begin
               sh_in  = h_mod;
               rem_in = '0;
               cnt_in = cht_pkg::DIGIT_CNT_W'(cht_pkg::HASH_DIGITS);
            end else if (cnt_ff != '0) begin
               sh_in   = sh_ff << cht_pkg::DIGIT_W;
               rem_in  = r[BKT_W-1:0];
               cnt_in  = cnt_ff - cht_pkg::DIGIT_CNT_W'(1);
               done_in = (cnt_ff == cht_pkg::DIGIT_CNT_W'(1));
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               cnt_ff  <= '0;
               done_ff <= 1'b0;
            end else begin
               cnt_ff  <= cnt_in;
               done_ff <= done_in;
            end
            sh_ff  <= sh_in;
            rem_ff <= rem_in;
         end

         assign done   = done_ff;
         assign bucket = rem_ff;
      end
   endgenerate

endmodule

// ===== src/chained_hash_table.sv =====
// Chained hash table. A request is hashed, its bucket head read and its chain walked
// entry by entry to a key match or the end; an append behind a non-empty chain adds a
// link step. A new word is taken only once the reply to the last one is loaded; the
// serial chain walk on the entry RAM read port and waits on rsp_ready set the rate.
// Reset clears control and the entry count, then sweeps over all NUM_BUCKETS bucket
// heads; req_ready stays low until that sweep is done.
module chained_hash_table #(
   parameter int NUM_BUCKETS    = cht_pkg::NUM_BUCKETS_DEFAULT,
   parameter int ENTRY_CAPACITY = cht_pkg::ENTRY_CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [cht_pkg::KEY_W-1:0]    req_key,
   input  logic [cht_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cht_pkg::STATUS_W-1:0] rsp_status,
   output logic [cht_pkg::VALUE_W-1:0]  rsp_found_value,
   output logic [cht_pkg::TOTAL_W-1:0]  rsp_entry_total
);

   localparam int KW    = cht_pkg::KEY_W;
   localparam int VW    = cht_pkg::VALUE_W;
   localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int EA_W  = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;
   localparam int IDX_W = $clog2(ENTRY_CAPACITY + 1);
   localparam int ENT_W = KW + VW + IDX_W;
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(ENTRY_CAPACITY);

   cht_pkg::state_type  state_ff, state_in;
   cht_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                  cmd_ff, cmd_in;
   logic [KW-1:0]         key_ff, key_in;
   logic [VW-1:0]         value_ff, value_in;
   logic [BKT_W-1:0]      bkt_ff, bkt_in;
   logic [BKT_W-1:0]      clr_ff, clr_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic [KW-1:0]         ent_key_ff, ent_key_in;
   logic [VW-1:0]         ent_val_ff, ent_val_in;
   logic [IDX_W-1:0]      ent_link_ff, ent_link_in;
   logic                  hit_ff, hit_in;
   logic                  empty_ff, empty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]         rsp_value_ff, rsp_value_in;
   logic [cht_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                  rsp_load;

   logic                  hash_done;
   logic [BKT_W-1:0]      hash_bucket;

   logic                  head_we;
   logic [BKT_W-1:0]      head_waddr;
   logic [IDX_W-1:0]      head_wdata;
   logic [IDX_W-1:0]      head_rdata;
   logic                  ent_we;
   logic [EA_W-1:0]       ent_waddr, ent_raddr;
   logic [ENT_W-1:0]      ent_wdata, ent_rdata;

   logic                  req_accept, out_free;
   logic                  head_stop, link_stop, ent_match;
   logic                  pool_full, is_lookup, append_tail;
   logic [KW-1:0]         ent_key_q;
   logic [VW-1:0]         ent_val_q;
   logic [IDX_W-1:0]      ent_link_q;

   cht_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .key    (req_key),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   cht_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (hash_bucket),
      .rd_data (head_rdata)
   );

   cht_ram #(.WIDTH(ENT_W), .DEPTH(ENTRY_CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   assign req_ready  = (state_ff == cht_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign ent_key_q  = ent_rdata[ENT_W-1 -: KW];
   assign ent_val_q  = ent_rdata[IDX_W +: VW];
   assign ent_link_q = ent_rdata[IDX_W-1:0];

   assign head_stop   = (head_rdata >= count_ff);
   assign link_stop   = (ent_link_q >= count_ff);
   assign ent_match   = (ent_key_q == key_ff);
   assign pool_full   = (count_ff == NULL_IDX);
   assign is_lookup   = (cmd_ff == cht_pkg::CMD_LOOKUP);
   assign append_tail = !is_lookup && !hit_ff && !pool_full && !empty_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cht_pkg::ST_CLEAR: begin
            if (clr_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = cht_pkg::ST_IDLE;
            end
         end
         cht_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = cht_pkg::ST_HASH;
            end
         end
         cht_pkg::ST_HASH: begin
            if (hash_done) begin
               state_in = cht_pkg::ST_HEAD;
            end
         end
         cht_pkg::ST_HEAD: begin
            state_in = head_stop ? cht_pkg::ST_DECIDE : cht_pkg::ST_WALK;
         end
         cht_pkg::ST_WALK: begin
            if (ent_match || link_stop) begin
               state_in = cht_pkg::ST_DECIDE;
            end
         end
         cht_pkg::ST_DECIDE: begin
            if (append_tail) begin
               state_in = cht_pkg::ST_LINK;
            end else if (out_free) begin
               state_in = cht_pkg::ST_IDLE;
            end
         end
         cht_pkg::ST_LINK: begin
            if (out_free) begin
               state_in = cht_pkg::ST_IDLE;
            end
         end
         default: state_in = cht_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      bkt_in        = bkt_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      ent_key_in    = ent_key_ff;
      ent_val_in    = ent_val_ff;
      ent_link_in   = ent_link_ff;
      hit_in        = hit_ff;
      empty_in      = empty_ff;
      head_we       = 1'b0;
      head_waddr    = bkt_ff;
      head_wdata    = count_ff;
      ent_we        = 1'b0;
      ent_waddr     = cur_ff[EA_W-1:0];
      ent_wdata     = {key_ff, value_ff, NULL_IDX};
      ent_raddr     = head_rdata[EA_W-1:0];
      rsp_load      = 1'b0;
      rsp_status_in = cht_pkg::STAT_MISSING;
      rsp_value_in  = '0;
      case (state_ff)
         cht_pkg::ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NULL_IDX;
            clr_in     = clr_ff + BKT_W'(1);
         end
         cht_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_cmd;
               key_in   = req_key;
               value_in = req_value;
            end
         end
         cht_pkg::ST_HASH: begin
            bkt_in = hash_bucket;
         end
         cht_pkg::ST_HEAD: begin
            cur_in   = head_rdata;
            empty_in = head_stop;
            hit_in   = 1'b0;
         end
         cht_pkg::ST_WALK: begin
            ent_raddr   = ent_link_q[EA_W-1:0];
            ent_key_in  = ent_key_q;
            ent_val_in  = ent_val_q;
            ent_link_in = ent_link_q;
            hit_in      = ent_match;
            if (!ent_match && !link_stop) begin
               cur_in = ent_link_q;
            end
         end
         cht_pkg::ST_DECIDE: begin
            if (append_tail) begin
               ent_we    = 1'b1;
               ent_waddr = count_ff[EA_W-1:0];
            end else if (out_free) begin
               rsp_load = 1'b1;
               if (is_lookup) begin
                  rsp_status_in = hit_ff ? cht_pkg::STAT_FOUND : cht_pkg::STAT_MISSING;
                  rsp_value_in  = hit_ff ? ent_val_ff : '0;
               end else if (hit_ff) begin
                  ent_we        = 1'b1;
                  ent_wdata     = {ent_key_ff, value_ff, ent_link_ff};
                  rsp_status_in = cht_pkg::STAT_UPDATED;
               end else if (pool_full) begin
                  rsp_status_in = cht_pkg::STAT_FULL;
               end else begin
                  ent_we        = 1'b1;
                  ent_waddr     = count_ff[EA_W-1:0];
                  head_we       = 1'b1;
                  count_in      = count_ff + IDX_W'(1);
                  rsp_status_in = cht_pkg::STAT_NEW;
               end
            end
         end
         cht_pkg::ST_LINK: begin
            if (out_free) begin
               ent_we        = 1'b1;
               ent_wdata     = {ent_key_ff, ent_val_ff, count_ff};
               count_in      = count_ff + IDX_W'(1);
               rsp_load      = 1'b1;
               rsp_status_in = cht_pkg::STAT_NEW;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      rsp_total_in = cht_pkg::TOTAL_W'(count_in);
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cht_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      bkt_ff      <= bkt_in;
      cur_ff      <= cur_in;
      ent_key_ff  <= ent_key_in;
      ent_val_ff  <= ent_val_in;
      ent_link_ff <= ent_link_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_total_ff  <= rsp_total_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_entry_total = rsp_total_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NULL_IDX)
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> count_ff == $past(count_ff) + IDX_W'(1))
      else $error("entry count moved by other than one");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff) == cht_pkg::ST_DECIDE || $past(state_ff) == cht_pkg::ST_LINK)
      else $error("result word raised outside resolve states");

   a_entry_write: assert property (@(posedge clock) disable iff (reset)
      ent_we |-> IDX_W'(ent_waddr) <= count_ff)
      else $error("entry write beyond allocated pool");
`endif

endmodule

// ===== tb/cht_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the chained hash table: mirrors bucket chains and the entry pool,
// predicts the reply to each accepted request word and checks reply words in order.
// Depends on cht_pkg for field widths, command codes and status codes.
module cht_checker #(
   parameter int NUM_BUCKETS    = cht_pkg::NUM_BUCKETS_DEFAULT,
   parameter int ENTRY_CAPACITY = cht_pkg::ENTRY_CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [cht_pkg::KEY_W-1:0]    req_key,
   input  logic [cht_pkg::VALUE_W-1:0]  req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [cht_pkg::STATUS_W-1:0] rsp_status,
   input  logic [cht_pkg::VALUE_W-1:0]  rsp_found_value,
   input  logic [cht_pkg::TOTAL_W-1:0]  rsp_entry_total,
   output int                           fail_count,
   output int                           outstanding
);

   typedef struct {
      cht_pkg::status_type          status;
      logic [cht_pkg::VALUE_W-1:0]  found_value;
      logic [cht_pkg::TOTAL_W-1:0]  entry_total;
   } reply_type;

   int unsigned                 chain_head [NUM_BUCKETS];
   logic [cht_pkg::KEY_W-1:0]   slot_key   [ENTRY_CAPACITY];
   logic [cht_pkg::VALUE_W-1:0] slot_value [ENTRY_CAPACITY];
   int unsigned                 slot_next  [ENTRY_CAPACITY];
   int unsigned                 slots_used;
   reply_type                   replies_due[$];

   function automatic int unsigned home_bucket(logic [cht_pkg::KEY_W-1:0] key);
      logic [63:0] product;
      product = {32'd0, key} * {32'd0, cht_pkg::HASH_MULT};
      return int'((product % {32'd0, cht_pkg::HASH_MOD}) % 64'(NUM_BUCKETS));
   endfunction

   function automatic reply_type hash_access(logic cmd, logic [cht_pkg::KEY_W-1:0] key,
                                             logic [cht_pkg::VALUE_W-1:0] value);
      reply_type   r;
      int unsigned bucket;
      int unsigned cur;
      int unsigned last;
      int unsigned hit;
      bucket = home_bucket(key);
      cur    = chain_head[bucket];
      last   = ENTRY_CAPACITY;
      hit    = ENTRY_CAPACITY;
      for (int hops = 0; hops < ENTRY_CAPACITY; hops++) begin
         if (cur >= slots_used) break;
         if (slot_key[cur] == key) begin
            hit = cur;
            break;
         end
         last = cur;
         cur  = slot_next[cur];
      end
      r.found_value = '0;
      if (cmd == cht_pkg::CMD_LOOKUP) begin
         if (hit != ENTRY_CAPACITY) begin
            r.status      = cht_pkg::STAT_FOUND;
            r.found_value = slot_value[hit];
         end else begin
            r.status = cht_pkg::STAT_MISSING;
         end
      end else if (hit != ENTRY_CAPACITY) begin
         slot_value[hit] = value;
         r.status        = cht_pkg::STAT_UPDATED;
      end else if (slots_used >= ENTRY_CAPACITY) begin
         r.status = cht_pkg::STAT_FULL;
      end else begin
         slot_key[slots_used]   = key;
         slot_value[slots_used] = value;
         slot_next[slots_used]  = ENTRY_CAPACITY;
         if (last == ENTRY_CAPACITY) begin
            chain_head[bucket] = slots_used;
         end else begin
            slot_next[last] = slots_used;
         end
         slots_used++;
         r.status = cht_pkg::STAT_NEW;
      end
      r.entry_total = cht_pkg::TOTAL_W'(slots_used);
      return r;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) chain_head[b] = ENTRY_CAPACITY;
         slots_used = 0;
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $error("reply word with no request outstanding");
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_found_value !== want.found_value) begin
                  $error("found_value: expected %h, got %h", want.found_value,
                         rsp_found_value);
                  fail_count++;
               end
               if (rsp_entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp_entry_total);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            replies_due.push_back(hash_access(req_cmd, req_key, req_value));
         end
      end
      outstanding = replies_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the chained hash table testbench: clock, reset, request words and reply stalls.
// Depends on cht_pkg, the chained_hash_table block and the cht_checker scoreboard.
module tb_top;

   localparam int ENTRY_CAPACITY = cht_pkg::ENTRY_CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT    = 1_000_000;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_cmd   = cht_pkg::CMD_INSERT;
   logic [cht_pkg::KEY_W-1:0]    req_key   = '0;
   logic [cht_pkg::VALUE_W-1:0]  req_value = '0;
   logic                         rsp_ready = 1'b0;
   logic                         req_ready;
   logic                         rsp_valid;
   logic [cht_pkg::STATUS_W-1:0] rsp_status;
   logic [cht_pkg::VALUE_W-1:0]  rsp_found_value;
   logic [cht_pkg::TOTAL_W-1:0]  rsp_entry_total;

   int fail_count;
   int outstanding;
   int cycles    = 0;
   int rsp_stall = 0;
   bit idle_on   = 1'b1;

   logic [cht_pkg::KEY_W-1:0] stored_keys[$];
   bit                        key_seen[logic [cht_pkg::KEY_W-1:0]];

   chained_hash_table DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_total (rsp_entry_total)
   );

   cht_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_total (rsp_entry_total),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** chained_hash_table: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(1, 16);
      end
      rsp_ready <= (rsp_stall == 0);
   end

   function automatic logic [cht_pkg::VALUE_W-1:0] data_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [cht_pkg::KEY_W-1:0] fresh_key();
      logic [cht_pkg::KEY_W-1:0] k;
      do k = $urandom; while (key_seen.exists(k));
      return k;
   endfunction

   function automatic logic [cht_pkg::KEY_W-1:0] known_key();
      if (stored_keys.size() == 0) return $urandom;
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
   endfunction

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_word(input logic cmd, input logic [cht_pkg::KEY_W-1:0] key,
                            input logic [cht_pkg::VALUE_W-1:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic insert_word(input logic [cht_pkg::KEY_W-1:0] key,
                              input logic [cht_pkg::VALUE_W-1:0] value);
      if (!key_seen.exists(key) && key_seen.num() < ENTRY_CAPACITY) begin
         key_seen[key] = 1'b1;
         stored_keys.push_back(key);
      end
      send_word(cht_pkg::CMD_INSERT, key, value);
   endtask

   task automatic mixed_word(input int p_new, input int p_upd, input int p_hit);
      int r;
      r = $urandom_range(0, 99);
      if (r < p_new) begin
         insert_word(fresh_key(), data_word());
      end else if (r < p_new + p_upd) begin
         insert_word(known_key(), data_word());
      end else if (r < p_new + p_upd + p_hit) begin
         send_word(cht_pkg::CMD_LOOKUP, known_key(), data_word());
      end else begin
         send_word(cht_pkg::CMD_LOOKUP, fresh_key(), data_word());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table, then keys 0 and all-ones which share bucket 0
      send_word(cht_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      insert_word(32'h0000_0000, 32'h0000_0000);
      send_word(cht_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      insert_word(32'hffff_ffff, 32'hffff_ffff);
      send_word(cht_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
      insert_word(32'h0000_0000, 32'hffff_ffff);
      insert_word(32'hffff_ffff, 32'h0000_0000);
      send_word(cht_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_word(cht_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
      insert_word(32'h0000_0001, 32'ha5a5_a5a5);
      insert_word(32'h8000_0000, 32'h5a5a_5a5a);
      insert_word(32'h7fff_ffff, 32'h1234_5678);
      send_word(cht_pkg::CMD_LOOKUP, 32'h0000_0001, 32'hffff_ffff);
      send_word(cht_pkg::CMD_LOOKUP, 32'h0000_0002, 32'h0000_0000);
      insert_word(32'h0000_0001, 32'h0000_0000);
      send_word(cht_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_word(cht_pkg::CMD_LOOKUP, 32'h7fff_ffff, 32'h0000_0000);

      for (int i = 0; i < 700; i++) begin
         idle_on = !(i >= 300 && i < 400);
         mixed_word(45, 15, 25);
      end

      idle_on = 1'b1;
      while (key_seen.num() < ENTRY_CAPACITY) mixed_word(85, 5, 10);

      // pool is full from here on
      for (int i = 0; i < 250; i++) begin
         idle_on = (i < 150);
         mixed_word(35, 25, 30);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (64) @(posedge clock);
      if (fail_count == 0) begin
         $display("** chained_hash_table: PASSED **");
      end else begin
         $display("** chained_hash_table: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/cht_pkg.sv
src/cht_ram.sv
src/cht_hash.sv
src/chained_hash_table.sv
tb/cht_checker.sv
tb/tb_top.sv
